// ===== rtl/core/kpuq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpuq_pkg
// Shared types and constants for the keyed priority upload queue.
// ----------------------------------------------------------------------------
package kpuq_pkg;
  localparam int QueueDepth = 16;
  localparam int TableDepth = 16;
  localparam int KeyBits    = 32;
  localparam int HandleBits = 16;
  localparam int PrioBits   = 16;
  localparam int CountBits  = $clog2(QueueDepth + 1);
  localparam int QIdxBits   = $clog2(QueueDepth);
  localparam int TIdxBits   = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  localparam logic [2:0] FuncPush   = 3'd0;
  localparam logic [2:0] FuncPop    = 3'd1;
  localparam logic [2:0] FuncClear  = 3'd2;
  localparam logic [2:0] FuncAdd    = 3'd3;
  localparam logic [2:0] FuncCommit = 3'd4;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusEmpty   = 2'd1;
  localparam logic [1:0] StatusQFull   = 2'd2;
  localparam logic [1:0] StatusTblFull = 2'd3;

  typedef struct packed {
    logic [2:0]            func;
    logic [31:0]           tile_key;
    logic [15:0]           cmd_handle;
    logic signed [15:0]    entry_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] popped_handle;
    logic [4:0]  queue_count;
  } rsp_t;

  typedef struct packed {
    logic                  valid;
    logic [KeyBits-1:0]    key;
    logic [HandleBits-1:0] handle;
    logic signed [PrioBits-1:0] prio;
  } slot_t;

  // Control from the sequencer to each queue cell.
  typedef struct packed {
    logic                  shift;   // take the neighbor's entry if at/after gap
    logic [QIdxBits-1:0]   gap;     // index of the removed slot
    logic                  rot;     // rotate the ring by one cell
    logic                  reprio;  // the last cell takes the new priority on rotate
    logic signed [PrioBits-1:0] new_prio;
  } cell_ctrl_t;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StLook   = 6'b000010,
    StScan   = 6'b000100,
    StRemove = 6'b001000,
    StReprio = 6'b010000,
    StResp   = 6'b100000
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/core/kpuq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpuq_req_if / kpuq_rsp_if
// Valid-ready channels for requests and results.
// ----------------------------------------------------------------------------
interface kpuq_req_if import kpuq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kpuq_rsp_if import kpuq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kpuq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpuq_cell
// One queue slot; it rotates with its neighbors and closes a gap on pop.
// ----------------------------------------------------------------------------
module kpuq_cell import kpuq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [QIdxBits-1:0] idx_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire slot_t              nbr_i,
  input  wire slot_t              load_i,
  input  wire logic               load_en_i,
  output slot_t                   slot_o
);
  slot_t slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (load_en_i) begin
      slot_d = load_i;
    end else if (ctrl_i.rot) begin
      slot_d = nbr_i;
      if (ctrl_i.reprio && idx_i == QIdxBits'(QueueDepth - 1)) slot_d.prio = ctrl_i.new_prio;
    end else if (ctrl_i.shift && idx_i >= ctrl_i.gap) begin
      slot_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q.valid <= 1'b0;
      slot_q.key <= '0;
      slot_q.handle <= '0;
      slot_q.prio <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
endmodule
`default_nettype wire

// ===== rtl/core/keyed_priority_upload_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_priority_upload_queue_top
// Priority queue of upload handles with a staged key-to-priority table.
// ----------------------------------------------------------------------------
// One request is handled at a time, from the cycle it is accepted until its
// result is loaded. Push without filtering, push on a full queue, pop on an
// empty queue, clear and unused codes go straight to the result; a push with
// filtering on and an add walk the table one entry a cycle; a pop does a min
// scan over the occupied cells, then a shift; and a commit rotates the ring
// by one cell after each full table lookup of its head.
// The result sits in its own register, so a new request is taken while it
// waits; only the next result stage stalls until it has been accepted.
module keyed_priority_upload_queue_top import kpuq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  kpuq_req_if.sink   req,
  kpuq_rsp_if.source rsp
);
  logic signed [PrioBits-1:0] inact_q;
  state_e state_q, state_d;
  req_t req_q;
  logic [CountBits-1:0] cnt_q;
  logic [TIdxBits:0] tix_q;
  logic [CountBits-1:0] qix_q;
  logic [QIdxBits-1:0] best_q;
  logic signed [PrioBits-1:0] bestp_q;
  logic [HandleBits-1:0] besth_q;
  logic hit_q;
  logic signed [PrioBits-1:0] hitp_q;
  logic [TIdxBits:0] free_q;
  logic filter_q;
  logic rsp_valid_q;
  rsp_t rsp_q;
  logic [1:0] sts_q;
  logic [HandleBits-1:0] pop_q;
  logic [TableDepth-1:0] act_v_q, stg_v_q;
  logic [KeyBits-1:0] act_k_q [TableDepth];
  logic signed [PrioBits-1:0] act_p_q [TableDepth];
  logic [KeyBits-1:0] stg_k_q [TableDepth];
  logic signed [PrioBits-1:0] stg_p_q [TableDepth];
  slot_t cells [QueueDepth];
  cell_ctrl_t ctrl;
  logic load_en;
  slot_t load_d;
  logic [TIdxBits-1:0] ti;
  logic [KeyBits-1:0] look_key;
  logic tbl_v;
  logic [KeyBits-1:0] tbl_k;
  logic signed [PrioBits-1:0] tbl_p;
  logic lookup_done;
  logic commit_mode;

  assign req.ready = state_q == StIdle;
  assign rsp.valid = rsp_valid_q;
  assign rsp.data = rsp_q;
  assign ti = tix_q[TIdxBits-1:0];
  assign commit_mode = req_q.func == FuncCommit;
  assign look_key = commit_mode ? cells[0].key : req_q.tile_key;
  assign tbl_v = (req_q.func == FuncAdd) ? stg_v_q[ti] : act_v_q[ti];
  assign tbl_k = (req_q.func == FuncAdd) ? stg_k_q[ti] : act_k_q[ti];
  assign tbl_p = (req_q.func == FuncAdd) ? stg_p_q[ti] : act_p_q[ti];
  assign lookup_done = tix_q == (TIdxBits+1)'(TableDepth - 1);

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    kpuq_cell u_cell (
      .clk_i, .rst_ni,
      .idx_i(QIdxBits'(g)),
      .ctrl_i(ctrl),
      .nbr_i((g == QueueDepth - 1) ? cells[0] : cells[(g + 1) % QueueDepth]),
      .load_i(load_d),
      .load_en_i(load_en && cnt_q[QIdxBits-1:0] == QIdxBits'(g)),
      .slot_o(cells[g])
    );
  end

  logic signed [PrioBits-1:0] found_p;
  logic found;
  assign found = hit_q || (tbl_v && tbl_k == look_key);
  assign found_p = hit_q ? hitp_q : tbl_p;

  always_comb begin
    state_d = state_q;
    ctrl = '0;
    ctrl.gap = best_q;
    load_en = 1'b0;
    load_d.valid = 1'b1;
    load_d.key = req_q.tile_key;
    load_d.handle = req_q.cmd_handle;
    load_d.prio = '0;
    case (state_q)
      StIdle: if (req.valid) state_d = StLook;
      StLook: begin
        case (req_q.func)
          FuncPush: begin
            if (cnt_q == CountBits'(QueueDepth) || !filter_q) state_d = StResp;
            else if (lookup_done) state_d = StResp;
            load_en = cnt_q != CountBits'(QueueDepth) &&
                      (!filter_q || lookup_done);
            load_d.prio = !filter_q ? '0 : (found ? found_p : inact_q);
          end
          FuncPop: state_d = (cnt_q == '0) ? StResp : StScan;
          FuncAdd: if (lookup_done) state_d = StResp;
          FuncCommit: state_d = StReprio;
          default: state_d = StResp;
        endcase
      end
      StScan: if (qix_q == cnt_q) state_d = StRemove;
      StRemove: begin
        ctrl.shift = 1'b1;
        state_d = StResp;
      end
      StReprio: begin
        if (lookup_done) begin
          ctrl.rot = 1'b1;
          ctrl.reprio = qix_q < cnt_q;
          ctrl.new_prio = found ? found_p : inact_q;
          if (qix_q == CountBits'(QueueDepth - 1)) state_d = StResp;
        end
      end
      StResp: if (!rsp_valid_q || rsp.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      inact_q <= 16'sh7fff;
      cnt_q <= '0;
      filter_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      act_v_q <= '0;
      stg_v_q <= '0;
      tix_q <= '0;
      qix_q <= '0;
      hit_q <= 1'b0;
      free_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) inact_q <= cfg_wdata_i;
      if (state_q == StResp && state_d == StIdle) rsp_valid_q <= 1'b1;
      else if (rsp.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (req.valid) req_q <= req.data;
          tix_q <= '0;
          qix_q <= '0;
          hit_q <= 1'b0;
          free_q <= (TIdxBits+1)'(TableDepth);
          sts_q <= StatusOk;
          pop_q <= '0;
          best_q <= '0;
          bestp_q <= cells[0].prio;
          besth_q <= cells[0].handle;
        end
        StLook: begin
          if (!commit_mode && !hit_q && tbl_v && tbl_k == look_key) begin
            hit_q <= 1'b1;
            hitp_q <= tbl_p;
            if (req_q.func == FuncAdd) stg_p_q[ti] <= req_q.entry_priority;
          end
          if (!tbl_v && free_q == (TIdxBits+1)'(TableDepth)) free_q <= tix_q;
          tix_q <= commit_mode ? '0 : tix_q + 1'b1;
          case (req_q.func)
            FuncPush: begin
              if (cnt_q == CountBits'(QueueDepth)) sts_q <= StatusQFull;
              else if (load_en) cnt_q <= cnt_q + 1'b1;
            end
            FuncPop: begin
              if (cnt_q == '0) sts_q <= StatusEmpty;
              qix_q <= CountBits'(1);
            end
            FuncClear: stg_v_q <= '0;
            FuncAdd: begin
              if (lookup_done && !found) begin
                if (free_q != (TIdxBits+1)'(TableDepth)) begin
                  stg_v_q[free_q[TIdxBits-1:0]] <= 1'b1;
                  stg_k_q[free_q[TIdxBits-1:0]] <= req_q.tile_key;
                  stg_p_q[free_q[TIdxBits-1:0]] <= req_q.entry_priority;
                end else if (!tbl_v) begin
                  stg_v_q[ti] <= 1'b1;
                  stg_k_q[ti] <= req_q.tile_key;
                  stg_p_q[ti] <= req_q.entry_priority;
                end else begin
                  sts_q <= StatusTblFull;
                end
              end
            end
            FuncCommit: begin
              act_v_q <= stg_v_q;
              for (int t = 0; t < TableDepth; t++) begin
                act_k_q[t] <= stg_k_q[t];
                act_p_q[t] <= stg_p_q[t];
              end
              filter_q <= 1'b1;
            end
            default: ;
          endcase
        end
        StScan: begin
          if (qix_q != cnt_q) begin
            if (cells[qix_q[QIdxBits-1:0]].prio < bestp_q) begin
              bestp_q <= cells[qix_q[QIdxBits-1:0]].prio;
              besth_q <= cells[qix_q[QIdxBits-1:0]].handle;
              best_q <= qix_q[QIdxBits-1:0];
            end
            qix_q <= qix_q + 1'b1;
          end
        end
        StRemove: begin
          pop_q <= besth_q;
          cnt_q <= cnt_q - 1'b1;
        end
        StReprio: begin
          if (lookup_done) begin
            tix_q <= '0;
            hit_q <= 1'b0;
            qix_q <= qix_q + 1'b1;
          end else begin
            if (!hit_q && tbl_v && tbl_k == look_key) begin
              hit_q <= 1'b1;
              hitp_q <= tbl_p;
            end
            tix_q <= tix_q + 1'b1;
          end
        end
        StResp: begin
          if (state_d == StIdle) begin
            rsp_q.status <= sts_q;
            rsp_q.popped_handle <= pop_q;
            rsp_q.queue_count <= cnt_q;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CountBits'(QueueDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp.ready |=> rsp_valid_q)
    else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRemove |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("pop count mismatch");
endmodule
`default_nettype wire
